### design/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared widths, entry formats, request codes and pipeline bundles of the
// table-driven DFA token scanner.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_SYMBOLS = 128;
  localparam int LENGTH_BITS = 16;

  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int PRIO_W      = 8;
  localparam int OP_W        = 2;
  localparam int TADDR_W     = STATE_W + SYM_W;
  localparam int TRANS_DEPTH = NUM_STATES * NUM_SYMBOLS;

  typedef logic [STATE_W-1:0]     state_t;
  typedef logic [SYM_W-1:0]       sym_t;
  typedef logic [PRIO_W-1:0]      prio_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [TADDR_W-1:0]     taddr_t;

  typedef enum logic [OP_W-1:0] {
    OP_WR_TRANS = 2'd0,
    OP_WR_INFO  = 2'd1,
    OP_BEGIN    = 2'd2,
    OP_SCAN     = 2'd3
  } op_t;

  typedef struct packed {
    logic   dead;
    state_t state;
  } trans_ent_t;

  typedef struct packed {
    logic  acc;
    prio_t prio;
  } info_ent_t;

  typedef struct packed {
    logic adv;
    logic scan_rd;
    logic trans_wr;
    logic info_wr;
  } tbl_ctl_t;

  typedef struct packed {
    logic   valid;
    logic   is_begin;
    logic   last;
    state_t cur;
  } s1_t;

  typedef struct packed {
    logic       valid;
    logic       is_begin;
    logic       last;
    state_t     cur;
    trans_ent_t nxt;
    info_ent_t  icur;
  } s2_t;

  typedef struct packed {
    logic       valid;
    logic       is_begin;
    logic       last;
    state_t     cur;
    trans_ent_t nxt;
    info_ent_t  icur;
    info_ent_t  inxt;
    trans_ent_t nxt2;
  } s3_t;

endpackage

### design/dfa_token_scanner_top.sv
// ----------------------------------------------------------------------------
// dfa_token_scanner_top
// Table-driven DFA lexer: loads transitions and per-state accept/priority
// words, then scans tokens one character per request.
// ----------------------------------------------------------------------------
// Requests: write transition, write state info, begin token (start state 0),
// scan character. A token ends on a dead transition, on a step from an
// accepting state into a state of strictly higher priority, or after the
// character flagged last plus one step on symbol 0; it then yields one
// result. One request is taken every cycle, with two exceptions: the input
// stalls while a token result reaches the last stage and the previous result
// is still waiting in the result register, and a state-info write that
// arrives directly behind a last-flagged character waits while that
// character's next-state info and symbol-zero reads are issued. A result
// passes through the transition read, the next-state info and symbol-zero
// reads and the end-of-text info read, with the token update feeding the
// result register. Tables come up undefined and need no clearing pass;
// every entry a token reaches must be written first.
// ----------------------------------------------------------------------------
module dfa_token_scanner_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dts_pkg::OP_W-1:0]  in_opcode,
  input  dts_pkg::state_t           in_state_id,
  input  dts_pkg::sym_t             in_symbol,
  input  dts_pkg::state_t           in_next_state,
  input  logic                      in_next_dead,
  input  logic                      in_accepting,
  input  dts_pkg::prio_t            in_priority_req,
  input  logic                      in_last_symbol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_matched,
  output dts_pkg::state_t           out_final_state,
  output dts_pkg::prio_t            out_token_priority,
  output dts_pkg::len_t             out_token_length
);
  import dts_pkg::*;

  op_t        in_op;
  logic       adv;
  logic       hold;
  logic       hazard;
  logic       accept;
  state_t     cur_spec;
  logic       zero_sel_r;
  logic       zero_sel_nxt;
  tbl_ctl_t   tbl_ctl;
  trans_ent_t trans_wdata;
  info_ent_t  info_wdata;
  trans_ent_t t_rd;
  trans_ent_t t0_rd;
  info_ent_t  ia_rd;
  info_ent_t  ib_rd;
  info_ent_t  ic_rd;
  s1_t        s1_r;
  s1_t        s1_nxt;
  s2_t        s2_r;
  s2_t        s2_nxt;
  s3_t        s3_r;
  s3_t        s3_nxt;

  assign in_op    = op_t'(in_opcode);
  assign adv      = !hold;
  assign hazard   = s1_r.valid && !s1_r.is_begin && s1_r.last && (in_op == OP_WR_INFO);
  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;
  assign cur_spec = zero_sel_r ? '0 : t_rd.state;

  always_comb begin
    tbl_ctl.adv      = adv;
    tbl_ctl.scan_rd  = accept && (in_op == OP_SCAN);
    tbl_ctl.trans_wr = accept && (in_op == OP_WR_TRANS);
    tbl_ctl.info_wr  = accept && (in_op == OP_WR_INFO);
    trans_wdata.dead  = in_next_dead;
    trans_wdata.state = in_next_state;
    info_wdata.acc    = in_accepting;
    info_wdata.prio   = in_priority_req;
  end

  always_comb begin
    zero_sel_nxt = zero_sel_r;
    if (accept && (in_op == OP_BEGIN)) begin
      zero_sel_nxt = 1'b1;
    end else if (tbl_ctl.scan_rd) begin
      zero_sel_nxt = 1'b0;
    end
  end

  always_comb begin
    s1_nxt.valid    = accept && ((in_op == OP_BEGIN) || (in_op == OP_SCAN));
    s1_nxt.is_begin = (in_op == OP_BEGIN);
    s1_nxt.last     = in_last_symbol;
    s1_nxt.cur      = cur_spec;

    s2_nxt.valid    = s1_r.valid;
    s2_nxt.is_begin = s1_r.is_begin;
    s2_nxt.last     = s1_r.last;
    s2_nxt.cur      = s1_r.cur;
    s2_nxt.nxt      = t_rd;
    s2_nxt.icur     = ia_rd;

    s3_nxt.valid    = s2_r.valid;
    s3_nxt.is_begin = s2_r.is_begin;
    s3_nxt.last     = s2_r.last;
    s3_nxt.cur      = s2_r.cur;
    s3_nxt.nxt      = s2_r.nxt;
    s3_nxt.icur     = s2_r.icur;
    s3_nxt.inxt     = ib_rd;
    s3_nxt.nxt2     = t0_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_sel_r <= 1'b1;
      s1_r       <= '0;
      s2_r       <= '0;
      s3_r       <= '0;
    end else if (adv) begin
      zero_sel_r <= zero_sel_nxt;
      s1_r       <= s1_nxt;
      s2_r       <= s2_nxt;
      s3_r       <= s3_nxt;
    end
  end

  dts_tables u_tables (
    .clk         (clk),
    .ctl         (tbl_ctl),
    .rd_state    (cur_spec),
    .rd_symbol   (in_symbol),
    .wr_state    (in_state_id),
    .wr_symbol   (in_symbol),
    .trans_wdata (trans_wdata),
    .info_wdata  (info_wdata),
    .t_rd        (t_rd),
    .ia_rd       (ia_rd),
    .ib_rd       (ib_rd),
    .t0_rd       (t0_rd),
    .ic_rd       (ic_rd)
  );

  dts_step u_step (
    .clk                (clk),
    .rst_n              (rst_n),
    .s3                 (s3_r),
    .inxt2              (ic_rd),
    .adv                (adv),
    .out_ready          (out_ready),
    .hold               (hold),
    .out_valid          (out_valid),
    .out_matched        (out_matched),
    .out_final_state    (out_final_state),
    .out_token_priority (out_token_priority),
    .out_token_length   (out_token_length)
  );

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (s2_r === $past(s2_r)) && (s3_r === $past(s3_r)))
    else $error("pipeline moved during a stall");

  a_scan_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_SCAN) |=> s1_r.valid && !s1_r.is_begin && !zero_sel_r)
    else $error("scan request not staged");

  a_begin_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_BEGIN) |=> s1_r.valid && s1_r.is_begin && zero_sel_r)
    else $error("begin request not staged");

endmodule

### design/dts_tables.sv
// ----------------------------------------------------------------------------
// dts_tables
// Transition table, symbol-zero transition copy and three copies of the
// per-state info table, each with a registered read port.
// ----------------------------------------------------------------------------
module dts_tables (
  input  logic                clk,
  input  dts_pkg::tbl_ctl_t   ctl,
  input  dts_pkg::state_t     rd_state,
  input  dts_pkg::sym_t       rd_symbol,
  input  dts_pkg::state_t     wr_state,
  input  dts_pkg::sym_t       wr_symbol,
  input  dts_pkg::trans_ent_t trans_wdata,
  input  dts_pkg::info_ent_t  info_wdata,
  output dts_pkg::trans_ent_t t_rd,
  output dts_pkg::info_ent_t  ia_rd,
  output dts_pkg::info_ent_t  ib_rd,
  output dts_pkg::trans_ent_t t0_rd,
  output dts_pkg::info_ent_t  ic_rd
);
  import dts_pkg::*;

  trans_ent_t trans_mem [TRANS_DEPTH];
  trans_ent_t trans0_mem [NUM_STATES];
  info_ent_t  info_a_mem [NUM_STATES];
  info_ent_t  info_b_mem [NUM_STATES];
  info_ent_t  info_c_mem [NUM_STATES];

  trans_ent_t t_rd_r;
  trans_ent_t t0_rd_r;
  info_ent_t  ia_rd_r;
  info_ent_t  ib_rd_r;
  info_ent_t  ic_rd_r;

  taddr_t     rd_addr;
  taddr_t     wr_addr;
  logic       t0_wr;

  assign rd_addr = {rd_state, rd_symbol};
  assign wr_addr = {wr_state, wr_symbol};
  assign t0_wr   = ctl.trans_wr && (wr_symbol == '0);

  always_ff @(posedge clk) begin
    if (ctl.trans_wr) begin
      trans_mem[wr_addr] <= trans_wdata;
    end
    if (ctl.scan_rd) begin
      t_rd_r <= trans_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (t0_wr) begin
      trans0_mem[wr_state] <= trans_wdata;
    end
    if (ctl.adv) begin
      t0_rd_r <= trans0_mem[t_rd_r.state];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.info_wr) begin
      info_a_mem[wr_state] <= info_wdata;
    end
    if (ctl.scan_rd) begin
      ia_rd_r <= info_a_mem[rd_state];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.info_wr) begin
      info_b_mem[wr_state] <= info_wdata;
    end
    if (ctl.adv) begin
      ib_rd_r <= info_b_mem[t_rd_r.state];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.info_wr) begin
      info_c_mem[wr_state] <= info_wdata;
    end
    if (ctl.adv) begin
      ic_rd_r <= info_c_mem[t0_rd_r.state];
    end
  end

  assign t_rd  = t_rd_r;
  assign t0_rd = t0_rd_r;
  assign ia_rd = ia_rd_r;
  assign ib_rd = ib_rd_r;
  assign ic_rd = ic_rd_r;

endmodule

### design/dts_step.sv
// ----------------------------------------------------------------------------
// dts_step
// Token state update: applies one DFA step (two for the last character),
// tracks scanning and the saturating length, and holds the result register.
// ----------------------------------------------------------------------------
module dts_step (
  input  logic               clk,
  input  logic               rst_n,
  input  dts_pkg::s3_t       s3,
  input  dts_pkg::info_ent_t inxt2,
  input  logic               adv,
  input  logic               out_ready,
  output logic               hold,
  output logic               out_valid,
  output logic               out_matched,
  output dts_pkg::state_t    out_final_state,
  output dts_pkg::prio_t     out_token_priority,
  output dts_pkg::len_t      out_token_length
);
  import dts_pkg::*;

  logic      scanning_r;
  logic      scanning_nxt;
  len_t      count_r;
  len_t      count_nxt;
  len_t      count1;
  len_t      count2;
  logic      res;
  state_t    fin;
  info_ent_t finfo;
  len_t      len_sel;

  logic      out_valid_r;
  logic      out_matched_r;
  state_t    out_final_state_r;
  prio_t     out_token_priority_r;
  len_t      out_token_length_r;

  always_comb begin
    count1       = (count_r == '1) ? count_r : len_t'(count_r + 1'b1);
    count2       = (count1 == '1) ? count1 : len_t'(count1 + 1'b1);
    res          = 1'b0;
    fin          = s3.cur;
    finfo        = s3.icur;
    scanning_nxt = scanning_r;
    count_nxt    = count_r;
    if (s3.valid && s3.is_begin) begin
      scanning_nxt = 1'b1;
      count_nxt    = '0;
    end else if (s3.valid && scanning_r) begin
      count_nxt = count1;
      priority if (s3.nxt.dead) begin
        res = 1'b1;
      end else if (!s3.last) begin
        if (s3.icur.acc && (s3.inxt.prio > s3.icur.prio)) begin
          res   = 1'b1;
          fin   = s3.nxt.state;
          finfo = s3.inxt;
        end
      end else begin
        res       = 1'b1;
        count_nxt = count2;
        fin       = s3.nxt.state;
        finfo     = s3.inxt;
        if (!s3.nxt2.dead && s3.inxt.acc && (inxt2.prio > s3.inxt.prio)) begin
          fin   = s3.nxt2.state;
          finfo = inxt2;
        end
      end
      if (res) begin
        scanning_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (!finfo.acc) begin
      len_sel = '0;
    end else if (count_nxt == '1) begin
      len_sel = '1;
    end else begin
      len_sel = len_t'(count_nxt - 1'b1);
    end
  end

  assign hold = out_valid_r && !out_ready && res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      count_r    <= '0;
    end else if (adv) begin
      scanning_r <= scanning_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res) begin
      out_matched_r        <= finfo.acc;
      out_final_state_r    <= fin;
      out_token_priority_r <= finfo.acc ? finfo.prio : '0;
      out_token_length_r   <= len_sel;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_matched        = out_matched_r;
  assign out_final_state    = out_final_state_r;
  assign out_token_priority = out_token_priority_r;
  assign out_token_length   = out_token_length_r;

  a_end_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res |=> !scanning_r)
    else $error("scanning still set after token end");

  a_begin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s3.valid && s3.is_begin |=> scanning_r && (count_r == '0))
    else $error("begin request did not restart the token");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res && !finfo.acc |=> (out_token_length_r == '0) && (out_token_priority_r == '0))
    else $error("unmatched token reports nonzero length or priority");

endmodule
